>>> hdl/qnn_pkg.sv
// Shared types, constants and latencies for the quaternion normalizer.
`default_nettype none
package qnn_pkg;

    // Newton steps toward 1/sqrt(s)
    localparam int NEWTON_STEPS = 4;
    // pipeline depth of one Q24.40 multiplier
    localparam int MUL_LAT      = 3;
    // one Newton step: three multiplies plus the registered subtract
    localparam int STEP_LAT     = 3 * MUL_LAT + 1;
    // side line from the norm sum to the output register
    localparam int DLY_LEN      = NEWTON_STEPS * STEP_LAT + MUL_LAT;

    localparam logic signed [63:0] Q40_THREE_HALVES = 64'sd3 <<< 39;
    localparam logic        [45:0] Q40_TWO          = 46'd2 << 40;
    localparam logic signed [31:0] Q30_ONE          = 32'sd1 <<< 30;

    typedef struct packed {
        logic signed [31:0] in_w;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_w;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               used_identity;
    } t_out;

    // per-item data that rides beside the Newton chain
    typedef struct packed {
        logic                     identity;
        logic signed [3:0][31:0]  comp;
    } t_side;

endpackage
`default_nettype wire

>>> hdl/qnn_mul.sv
// Pipelined Q24.40 multiplier: exact product, magnitude shifted right 40, saturated.
`default_nettype none
module qnn_mul
    import qnn_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    output logic signed [63:0]      o_p
);

    logic        r_neg_a, r_neg_b;
    logic [63:0] r_ma, r_mb;
    logic [63:0] r_p00, r_p01, r_p10, r_p11;
    logic        n_neg_a;
    logic [63:0] n_ma, n_mb;
    logic [127:0] full;
    logic [63:0]  mag;
    logic signed [63:0] n_p;

    // split into sign and magnitude
    always_comb begin
        n_neg_a = i_a[63] ^ i_b[63];
        n_ma    = i_a[63] ? (64'd0 - i_a) : i_a;
        n_mb    = i_b[63] ? (64'd0 - i_b) : i_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a <= n_neg_a;
            r_ma    <= n_ma;
            r_mb    <= n_mb;
            // four 32x32 partial products
            r_p00   <= {32'd0, r_ma[31:0]}  * {32'd0, r_mb[31:0]};
            r_p01   <= {32'd0, r_ma[31:0]}  * {32'd0, r_mb[63:32]};
            r_p10   <= {32'd0, r_ma[63:32]} * {32'd0, r_mb[31:0]};
            r_p11   <= {32'd0, r_ma[63:32]} * {32'd0, r_mb[63:32]};
            r_neg_b <= r_neg_a;
            o_p     <= n_p;
        end
    end

    // combine, shift and saturate
    always_comb begin
        full = {r_p11, 64'd0} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
             + {64'd0, r_p00};
        mag  = full[103:40];
        if (|full[127:104] || mag[63]) begin
            n_p = r_neg_b ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            n_p = r_neg_b ? (64'sd0 - $signed(mag)) : $signed(mag);
        end
    end

endmodule
`default_nettype wire

>>> hdl/qnn_step.sv
// One pipelined Newton step: y' = y * (1.5 - half * y * y).
`default_nettype none
module qnn_step
    import qnn_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [63:0] i_y,
    input  wire logic signed [63:0] i_half,
    output logic signed [63:0]      o_y,
    output logic signed [63:0]      o_half
);

    logic signed [63:0] r_half [STEP_LAT];
    logic signed [63:0] r_y    [2*MUL_LAT+1];
    logic signed [63:0] r_d;
    logic signed [63:0] t_sq, t_hs;

    // carry half and y alongside the multiplies
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_half[0] <= i_half;
            for (int i = 1; i < STEP_LAT; i++) r_half[i] <= r_half[i-1];
            r_y[0] <= i_y;
            for (int i = 1; i < 2*MUL_LAT+1; i++) r_y[i] <= r_y[i-1];
            // t_hs is never negative, so this cannot overflow
            r_d <= Q40_THREE_HALVES - t_hs;
        end
    end

    qnn_mul u_sq (.i_clk, .i_en, .i_a(i_y), .i_b(i_y), .o_p(t_sq));
    qnn_mul u_hs (.i_clk, .i_en, .i_a(r_half[MUL_LAT-1]), .i_b(t_sq), .o_p(t_hs));
    qnn_mul u_up (.i_clk, .i_en, .i_a(r_y[2*MUL_LAT]), .i_b(r_d), .o_p(o_y));

    assign o_half = r_half[STEP_LAT-1];

endmodule
`default_nettype wire

>>> hdl/quaternion_newton_normalize_unit.sv
// Quaternion normalizer top level: square lanes, norm merge, Newton chain, scale lanes.
//
//  port       dir  handshake          payload
//  in item    in   i_valid / o_stall  i_item (t_in)
//  out item   out  o_valid / i_stall  o_item (t_out)
//
// One item per cycle while no waiting result is stalled. Between the accepting edge and
// o_valid: the squares register on that edge, then the norm sum, each Newton step of three
// 3-stage multipliers and a subtract, the scaling multipliers and the output register.
// Synchronous active-low reset clears all valid bits.
// The whole pipeline holds while a waiting result is stalled.
`default_nettype none
module quaternion_newton_normalize_unit
    import qnn_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_item,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_item
);

    logic                    en;
    logic                    r_v1, r_v2;
    logic [DLY_LEN-1:0]      r_vld;
    logic signed [31:0]      c_in [4];
    logic [63:0]             r_sq [4];
    logic signed [3:0][31:0] r_c1, r_c2;
    logic [45:0]             r_s;
    t_side                   r_dly [DLY_LEN];
    t_side                   side_in;
    logic signed [63:0]      y_chain [NEWTON_STEPS+1];
    logic signed [63:0]      h_chain [NEWTON_STEPS+1];
    logic signed [63:0]      scaled [4];
    logic signed [31:0]      n_out [4];
    t_side                   tail;

    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // unpack the input components for the square lanes
    always_comb begin
        c_in[0] = i_item.in_w;
        c_in[1] = i_item.in_x;
        c_in[2] = i_item.in_y;
        c_in[3] = i_item.in_z;
    end

    // square lanes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1 <= {i_item.in_w, i_item.in_x, i_item.in_y, i_item.in_z};
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= 64'(c_in[i]) * 64'(c_in[i]);
            end
            r_c2 <= r_c1;
            r_s  <= 46'(r_sq[0][63:20]) + 46'(r_sq[1][63:20])
                  + 46'(r_sq[2][63:20]) + 46'(r_sq[3][63:20]);
        end
    end

    // merge: identity test on the norm, seed the Newton chain
    assign side_in.identity = (r_s >= Q40_TWO);
    assign side_in.comp     = r_c2;
    assign y_chain[0]       = $signed({18'd0, r_s});
    assign h_chain[0]       = $signed({19'd0, r_s[45:1]});

    for (genvar g = 0; g < NEWTON_STEPS; g++) begin : g_step
        qnn_step u_step (
            .i_clk, .i_en(en),
            .i_y(y_chain[g]), .i_half(h_chain[g]),
            .o_y(y_chain[g+1]), .o_half(h_chain[g+1])
        );
    end

    // side line and valid bits
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= side_in;
            for (int i = 1; i < DLY_LEN; i++) r_dly[i] <= r_dly[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_vld   <= {r_vld[DLY_LEN-2:0], r_v2};
            o_valid <= r_vld[DLY_LEN-1];
        end
    end

    // scale lanes
    for (genvar g = 0; g < 4; g++) begin : g_lane
        qnn_mul u_scale (
            .i_clk, .i_en(en),
            .i_a(64'($signed(r_dly[DLY_LEN-MUL_LAT-1].comp[3-g]))),
            .i_b(y_chain[NEWTON_STEPS]),
            .o_p(scaled[g])
        );
        always_comb begin
            if (scaled[g] > 64'sd2147483647) begin
                n_out[g] = 32'sh7fffffff;
            end else if (scaled[g] < -64'sd2147483648) begin
                n_out[g] = 32'sh80000000;
            end else begin
                n_out[g] = scaled[g][31:0];
            end
        end
    end

    assign tail = r_dly[DLY_LEN-1];

    // output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (tail.identity) begin
                o_item <= '{out_w: Q30_ONE, out_x: '0, out_y: '0, out_z: '0,
                            used_identity: 1'b1};
            end else begin
                o_item <= '{out_w: n_out[0], out_x: n_out[1], out_y: n_out[2],
                            out_z: n_out[3], used_identity: 1'b0};
            end
        end
    end

`ifndef ASSERT_OFF
    a_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.used_identity) |->
            (o_item.out_w == Q30_ONE && o_item.out_x == '0 &&
             o_item.out_y == '0 && o_item.out_z == '0))
        else $error("identity result with wrong payload");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(r_vld) && $stable(r_v1) && $stable(r_v2)))
        else $error("pipeline moved under a stalled result");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && r_vld == '0))
        else $error("valid bits survive reset");
`endif

endmodule
`default_nettype wire
